### design/tbcc_pkg.sv
// Shared constants for the timed battery charge controller.
`default_nettype none

package tbcc_pkg;

  localparam int ELAPSED_BITS   = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SUPPLY_MIN     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESENT_MIN    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISCHARGED_MAX = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHARGE_DURATION = 2'd3;

  localparam int SUPPLY_MIN_RESET      = 700;
  localparam int PRESENT_MIN_RESET     = 28;
  localparam int DISCHARGED_MAX_RESET  = 90;
  localparam int CHARGE_DURATION_RESET = 18000000;

endpackage

`default_nettype wire

### design/tbcc_if.sv
// Request and result channel interfaces of the timed battery charge controller.
`default_nettype none

interface tbcc_check_if #(
  parameter int ADC_BITS  = 10,
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic [ADC_BITS-1:0]  supply_sample;
  logic [ADC_BITS-1:0]  battery_sample;

  modport source (output valid, now_ms, supply_sample, battery_sample, input ready);
  modport sink   (input valid, now_ms, supply_sample, battery_sample, output ready);
endinterface

interface tbcc_result_if
  import tbcc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    charge_enable;
  logic                    charging_now;
  logic                    paused_now;
  logic [ELAPSED_BITS-1:0] elapsed_ms;

  modport source (output valid, charge_enable, charging_now, paused_now, elapsed_ms,
                  input ready);
  modport sink   (input valid, charge_enable, charging_now, paused_now, elapsed_ms,
                  output ready);
endinterface

`default_nettype wire

### design/timed_battery_charge_controller.sv
// Timed battery charge controller: one check per request, one result per check.
//
// Each accepted request is one check: the supply and battery ADC codes are
// compared with the threshold registers and the charge state (charging,
// paused, start and pause time stamps) is updated in the same cycle. The
// result is held in an output register; a new request is taken every cycle
// while that register is empty or being emptied, so the block sustains one
// check per clock; its result is valid in the cycle after acceptance. The
// state update is the single compare/subtract path from the request port
// to the state and result registers. Time arithmetic wraps mod 2^TIME_BITS.
// Configuration is a plain write port, taken at any edge with cfg_we && !rst.
`default_nettype none

module timed_battery_charge_controller
  import tbcc_pkg::*;
#(
  parameter int ADC_BITS  = 10,
  parameter int TIME_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  tbcc_check_if.sink                     checks,
  tbcc_result_if.source                  results,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0]      cfg_data
);

  logic [ADC_BITS-1:0]  supply_min;
  logic [ADC_BITS-1:0]  present_min;
  logic [ADC_BITS-1:0]  discharged_max;
  logic [TIME_BITS-1:0] charge_duration;

  logic                 charging;
  logic                 paused;
  logic                 enable;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] pause_time;

  logic                 charging_next;
  logic                 paused_next;
  logic                 enable_next;
  logic [TIME_BITS-1:0] start_time_next;
  logic [TIME_BITS-1:0] pause_time_next;
  logic [TIME_BITS-1:0] outage;
  logic [TIME_BITS-1:0] before_pause;
  logic [TIME_BITS-1:0] elapsed_full;

  logic                 out_valid;
  logic                 accept;

  assign checks.ready = !out_valid || results.ready;
  assign accept       = checks.valid && checks.ready;

  always_comb begin
    charging_next   = charging;
    paused_next     = paused;
    enable_next     = enable;
    start_time_next = start_time;
    pause_time_next = pause_time;
    outage          = checks.now_ms - pause_time;
    before_pause    = pause_time - start_time;
    if (checks.supply_sample >= supply_min) begin
      if (checks.battery_sample >= present_min) begin
        if (paused) begin
          enable_next = 1'b1;
          if (outage < before_pause) begin
            start_time_next = start_time + outage;
          end else begin
            start_time_next = checks.now_ms;
          end
          paused_next   = 1'b0;
          charging_next = 1'b1;
        end
        if (!charging_next) begin
          if (checks.battery_sample <= discharged_max) begin
            enable_next     = 1'b1;
            start_time_next = checks.now_ms;
            charging_next   = 1'b1;
          end
        end else if (charge_duration <= checks.now_ms - start_time_next) begin
          enable_next     = 1'b0;
          start_time_next = '0;
          charging_next   = 1'b0;
        end
      end else begin
        enable_next     = 1'b0;
        start_time_next = '0;
        charging_next   = 1'b0;
      end
    end else if (charging) begin
      enable_next     = 1'b0;
      pause_time_next = checks.now_ms;
      paused_next     = 1'b1;
      charging_next   = 1'b0;
    end
    elapsed_full = charging_next ? checks.now_ms - start_time_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_min      <= ADC_BITS'(SUPPLY_MIN_RESET);
      present_min     <= ADC_BITS'(PRESENT_MIN_RESET);
      discharged_max  <= ADC_BITS'(DISCHARGED_MAX_RESET);
      charge_duration <= TIME_BITS'(CHARGE_DURATION_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUPPLY_MIN:      supply_min      <= cfg_data[ADC_BITS-1:0];
        REG_PRESENT_MIN:     present_min     <= cfg_data[ADC_BITS-1:0];
        REG_DISCHARGED_MAX:  discharged_max  <= cfg_data[ADC_BITS-1:0];
        REG_CHARGE_DURATION: charge_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging   <= 1'b0;
      paused     <= 1'b0;
      enable     <= 1'b0;
      start_time <= '0;
      pause_time <= '0;
    end else if (accept) begin
      charging   <= charging_next;
      paused     <= paused_next;
      enable     <= enable_next;
      start_time <= start_time_next;
      pause_time <= pause_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.charge_enable <= enable_next;
      results.charging_now  <= charging_next;
      results.paused_now    <= paused_next;
      results.elapsed_ms    <= ELAPSED_BITS'(elapsed_full);
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire
